### rtl/core/slri_pkg.sv
// ----------------------------------------------------------------------------
// slri_pkg: shared types for the sorted list insert/remove unit
// Operation codes, result status codes and the command broadcast to cells.
// ----------------------------------------------------------------------------
package slri_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // broadcast to every cell in the row
    typedef struct packed {
        logic                     upd;
        logic                     mode;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

    // what a cell reports about itself to the top and its neighbors
    typedef struct packed {
        logic ge;   // valid and operand <= stored value
        logic eq;   // valid and operand == stored value
        logic hit;  // insert lands here or earlier
    } cell_flags_t;

endpackage

### rtl/core/slri_cell.sv
// ----------------------------------------------------------------------------
// slri_cell: one slot of the sorted row
// Holds one value and its valid bit; on an update it keeps its value, takes
// the operand, or takes a neighbor's value depending on local compares.
// ----------------------------------------------------------------------------
module slri_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  slri_pkg::cell_cmd_t                 cmd,
    input  logic                                prev_hit,
    input  logic                                prev_valid,
    input  logic signed [slri_pkg::DATA_W-1:0]  prev_value,
    input  logic                                next_valid,
    input  logic signed [slri_pkg::DATA_W-1:0]  next_value,
    output slri_pkg::cell_flags_t               flags,
    output logic                                valid_q,
    output logic signed [slri_pkg::DATA_W-1:0]  value_q,
    output logic                                valid_next_o,
    output logic signed [slri_pkg::DATA_W-1:0]  value_next_o
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [slri_pkg::DATA_W-1:0] value_reg;
    logic signed [slri_pkg::DATA_W-1:0] value_next;

    always_comb begin
        flags.ge  = valid_reg && (cmd.value <= value_reg);
        flags.eq  = valid_reg && (cmd.value == value_reg);
        flags.hit = flags.ge || !valid_reg;
    end

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.upd) begin
            if (cmd.mode == slri_pkg::MODE_INSERT) begin
                valid_next = prev_valid;
                if (prev_hit) begin
                    value_next = prev_value;   // shift up behind the new entry
                end else if (flags.hit) begin
                    value_next = cmd.value;    // first slot at or past the spot
                end
            end else begin
                valid_next = next_valid;
                // everything from the first equal entry on closes the gap
                if (flags.ge) begin
                    value_next = next_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid_q      = valid_reg;
    assign value_q      = value_reg;
    assign valid_next_o = valid_next;
    assign value_next_o = value_next;

endmodule

### rtl/core/sorted_list_insert_remove_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit: bounded ascending list of signed words
// Row of compare-and-shift cells with a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per operation. s_tuser selects insert or remove,
//   s_tdata carries the signed operand. An insert goes in front of the first
//   stored value not smaller than it; a remove drops the first equal entry.
//   Master channel: one beat per operation with status, count after the
//   operation, the smallest stored value and its valid flag.
//   The result is registered and appears the cycle after acceptance.
//   Throughput is one operation per cycle; every cell compares against the
//   broadcast operand in parallel and the row shifts in the same edge, so
//   the compare in each cell plus the match OR over the row sets the cycle.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken (it stays high when the beat leaves).
//   Reset empties the list; no clearing pass is needed since entries beyond
//   the count are never reported.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [6:2] count, [38:7] smallest,
                                   // [39] smallest_valid
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    slri_pkg::cell_cmd_t                cmd;
    slri_pkg::cell_flags_t              flags      [CAPACITY];
    logic                               valid_q    [CAPACITY];
    logic signed [slri_pkg::DATA_W-1:0] value_q    [CAPACITY];
    logic                               valid_nx   [CAPACITY];
    logic signed [slri_pkg::DATA_W-1:0] value_nx   [CAPACITY];
    logic [CAPACITY-1:0]                eq_vec;

    logic                               accept;
    logic                               found;
    slri_pkg::status_t                  status;

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [CNT_W+slri_pkg::COUNT_W-1:0] count_ext;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [39:0]                        out_data_reg;
    logic [39:0]                        out_data_next;
    logic signed [slri_pkg::DATA_W-1:0] smallest;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            eq_vec[k] = flags[k].eq;
        end
    end
    assign found = |eq_vec;

    always_comb begin
        status = slri_pkg::STATUS_DONE;
        if (s_tuser[0] == slri_pkg::MODE_INSERT) begin
            if (valid_q[CAPACITY-1]) begin
                status = slri_pkg::STATUS_FULL;
            end
        end else begin
            if (!valid_q[0]) begin
                status = slri_pkg::STATUS_EMPTY;
            end else if (!found) begin
                status = slri_pkg::STATUS_NOT_FOUND;
            end
        end
    end

    always_comb begin
        cmd.upd   = accept && (status == slri_pkg::STATUS_DONE);
        cmd.mode  = s_tuser[0];
        cmd.value = $signed(s_tdata);
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic                               p_hit;
        logic                               p_valid;
        logic signed [slri_pkg::DATA_W-1:0] p_value;
        logic                               n_valid;
        logic signed [slri_pkg::DATA_W-1:0] n_value;

        if (k == 0) begin : g_head
            assign p_hit   = 1'b0;
            assign p_valid = 1'b1;
            assign p_value = '0;
        end else begin : g_mid
            assign p_hit   = flags[k-1].hit;
            assign p_valid = valid_q[k-1];
            assign p_value = value_q[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign n_valid = 1'b0;
            assign n_value = '0;
        end else begin : g_body
            assign n_valid = valid_q[k+1];
            assign n_value = value_q[k+1];
        end

        slri_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cmd          (cmd),
            .prev_hit     (p_hit),
            .prev_valid   (p_valid),
            .prev_value   (p_value),
            .next_valid   (n_valid),
            .next_value   (n_value),
            .flags        (flags[k]),
            .valid_q      (valid_q[k]),
            .value_q      (value_q[k]),
            .valid_next_o (valid_nx[k]),
            .value_next_o (value_nx[k])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.upd) begin
            if (cmd.mode == slri_pkg::MODE_INSERT) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end
    assign count_ext = {{slri_pkg::COUNT_W{1'b0}}, count_next};

    assign smallest = valid_nx[0] ? value_nx[0] : '0;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {valid_nx[0], smallest,
                              count_ext[slri_pkg::COUNT_W-1:0], status};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### tb/slri_result_checker.sv
// ----------------------------------------------------------------------------
// slri_result_checker: scoreboard for the sorted list insert/remove unit
// Watches both stream channels. Each accepted operation is applied to a
// private sorted store to get the expected result. Each result beat is
// compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module slri_result_checker #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [1:0] status, [6:2] count, [38:7] smallest,
                                   // [39] smallest_valid
    output int          mismatches,
    output int          outstanding,
    output int          results_checked,
    output int          full_seen,
    output int          empty_seen,
    output int          miss_seen,
    output int          peak_fill
);

    typedef struct packed {
        slri_pkg::status_t                  status;
        logic [slri_pkg::COUNT_W-1:0]       count;
        logic signed [slri_pkg::DATA_W-1:0] smallest;
        logic                               smallest_valid;
    } list_result_t;

    list_result_t                       pending_results[$];
    logic signed [slri_pkg::DATA_W-1:0] held[CAPACITY];
    int                                 held_n = 0;

    int bad = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_miss = 0;
    int n_peak = 0;

    // applies one operation to the shadow store, returns the result it gives
    function automatic list_result_t apply_list_op(logic mode,
                                                   logic signed [slri_pkg::DATA_W-1:0] value);
        list_result_t r;
        int           pos;
        r.status = slri_pkg::STATUS_DONE;
        if (mode == slri_pkg::MODE_INSERT) begin
            if (held_n >= CAPACITY) begin
                r.status = slri_pkg::STATUS_FULL;
            end else begin
                // first slot whose value is not smaller than the operand
                pos = held_n;
                for (int k = held_n - 1; k >= 0; k--)
                    if (value <= held[k]) pos = k;
                for (int k = held_n; k > pos; k--)
                    held[k] = held[k-1];
                held[pos] = value;
                held_n++;
            end
        end else begin
            if (held_n == 0) begin
                r.status = slri_pkg::STATUS_EMPTY;
            end else begin
                pos = -1;
                for (int k = held_n - 1; k >= 0; k--)
                    if (held[k] == value) pos = k;
                if (pos < 0) begin
                    r.status = slri_pkg::STATUS_NOT_FOUND;
                end else begin
                    for (int k = pos; k + 1 < held_n; k++)
                        held[k] = held[k+1];
                    held_n--;
                end
            end
        end
        r.count          = slri_pkg::COUNT_W'(held_n);
        r.smallest_valid = (held_n > 0);
        r.smallest       = (held_n > 0) ? held[0] : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (!aresetn) begin
            held_n = 0;
            pending_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_list_op(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                got.status         = slri_pkg::status_t'(m_tdata[1:0]);
                got.count          = m_tdata[6:2];
                got.smallest       = m_tdata[38:7];
                got.smallest_valid = m_tdata[39];
                n_checked++;
                case (got.status)
                    slri_pkg::STATUS_FULL:      n_full++;
                    slri_pkg::STATUS_EMPTY:     n_empty++;
                    slri_pkg::STATUS_NOT_FOUND: n_miss++;
                    default: ;
                endcase
                if (pending_results.size() == 0) begin
                    if (bad < 10)
                        $display("[%0t] unexpected result beat: status=%s count=%0d %s",
                                 $realtime, got.status.name(), got.count,
                                 $sformatf("min=%0d valid=%0b", got.smallest,
                                           got.smallest_valid));
                    bad++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status || got.count != want.count ||
                        got.smallest != want.smallest ||
                        got.smallest_valid != want.smallest_valid) begin
                        if (bad < 10) begin
                            $display("[%0t] result mismatch on beat %0d", $realtime, n_checked);
                            $display("    expected: status=%s count=%0d min=%0d valid=%0b",
                                     want.status.name(), want.count, want.smallest,
                                     want.smallest_valid);
                            $display("    actual:   status=%s count=%0d min=%0d valid=%0b",
                                     got.status.name(), got.count, got.smallest,
                                     got.smallest_valid);
                        end
                        bad++;
                    end
                end
            end
            if (held_n > n_peak) n_peak = held_n;
        end
        mismatches      <= bad;
        outstanding     <= pending_results.size();
        results_checked <= n_checked;
        full_seen       <= n_full;
        empty_seen      <= n_empty;
        miss_seen       <= n_miss;
        peak_fill       <= n_peak;
    end

endmodule

### tb/sorted_list_insert_remove_unit_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit_tb: top of the sorted list unit testbench
// Drives insert/remove beats in random bursts against a randomly stalling
// receiver. A directed opening covers the value extremes, duplicates, remove
// on an empty list, a miss and an insert into a full list. Random phases then
// lean toward filling, draining or balance so that both ends are hit often.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit_tb;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_OPS   = 1650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [0:0]  s_tuser  = '0;   // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [1:0] status, [6:2] count, [38:7] smallest,
                                  // [39] smallest_valid

    int mismatches;
    int outstanding;
    int results_checked;
    int full_seen;
    int empty_seen;
    int miss_seen;
    int peak_fill;

    int cycle_count = 0;
    int burst_left  = 0;
    int ready_left  = 0;
    int ready_style = 0;
    int ops_sent    = 0;

    // values sent as inserts, used to pick remove targets that likely hit
    logic signed [31:0] inserted_pool[$];

    always #1 aclk = ~aclk;

    sorted_list_insert_remove_unit #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    slri_result_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .full_seen      (full_seen),
        .empty_seen     (empty_seen),
        .miss_seen      (miss_seen),
        .peak_fill      (peak_fill)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: always ready, coin flip, mostly stalled, or on/off runs set by bit 2 of ready_left
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_style = $urandom_range(3);
            ready_left  = $urandom_range(4, 60);
        end
        ready_left--;
        case (ready_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(1) == 1);
            2:       m_tready <= ($urandom_range(3) == 0);
            default: m_tready <= ready_left[2];
        endcase
    end

    // one beat; opens a new burst with a random gap when the old one is used up
    task automatic send_op(input logic mode, input logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        ops_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($urandom_range(16)) - 32'd8;   // dense, many duplicates
            4: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            5:       return 32'h8000_0000 + 32'($urandom_range(7));
            6:       return 32'h7FFF_FFFF - 32'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int          insert_pct;
        int          phase_left;
        int          idx;
        logic        mode;
        logic [31:0] value;

        insert_pct = 50;
        phase_left = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening
        send_op(slri_pkg::MODE_REMOVE, 32'd5);            // remove from empty list
        send_op(slri_pkg::MODE_INSERT, 32'h8000_0000);
        send_op(slri_pkg::MODE_INSERT, 32'h7FFF_FFFF);
        send_op(slri_pkg::MODE_INSERT, 32'h0000_0000);
        send_op(slri_pkg::MODE_INSERT, 32'hFFFF_FFFF);
        send_op(slri_pkg::MODE_INSERT, 32'h0000_0000);    // duplicate
        send_op(slri_pkg::MODE_REMOVE, 32'd5);            // miss
        send_op(slri_pkg::MODE_REMOVE, 32'h0000_0000);    // drops one of the duplicates
        for (int k = 0; k < 12; k++)
            send_op(slri_pkg::MODE_INSERT, 32'((k % 2 == 1) ? -k * 1000 : k * 1000));
        send_op(slri_pkg::MODE_INSERT, 32'd42);           // list is full now
        send_op(slri_pkg::MODE_REMOVE, 32'h7FFF_FFFF);    // largest entry
        send_op(slri_pkg::MODE_REMOVE, 32'h8000_0000);    // smallest entry, minimum moves

        // random phases leaning toward fill, balance or drain
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 50;
                    default: insert_pct = 20;
                endcase
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            mode = ($urandom_range(99) < insert_pct) ? slri_pkg::MODE_INSERT
                                                     : slri_pkg::MODE_REMOVE;
            if (mode == slri_pkg::MODE_REMOVE && inserted_pool.size() > 0 &&
                $urandom_range(99) < 75) begin
                idx   = $urandom_range(inserted_pool.size() - 1);
                value = inserted_pool[idx];
                inserted_pool.delete(idx);
            end else begin
                value = pick_value();
            end
            if (mode == slri_pkg::MODE_INSERT) begin
                inserted_pool.push_back(value);
                if (inserted_pool.size() > 48) void'(inserted_pool.pop_front());
            end
            send_op(mode, value);
        end
        s_tvalid <= 1'b0;

        // the checker's counter outputs are registered copies of its internal counts
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d operations sent, %0d results checked, peak fill %0d of %0d",
                 ops_sent, results_checked, peak_fill, CAPACITY);
        $display("rejected inserts on full list: %0d, removes on empty list: %0d, misses: %0d",
                 full_seen, empty_seen, miss_seen);
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sorted_list_insert_remove_unit.f
rtl/core/slri_pkg.sv
rtl/core/slri_cell.sv
rtl/core/sorted_list_insert_remove_unit.sv
tb/slri_result_checker.sv
tb/sorted_list_insert_remove_unit_tb.sv
